// ===== design/duration_rescale_assert.svh =====
// ----------------------------------------------------------------------------
// duration_rescale_assert.svh
// Assertion macros shared by the duration rescale design.
// ----------------------------------------------------------------------------
`ifndef DURATION_RESCALE_ASSERT_SVH
`define DURATION_RESCALE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during rst
`define DR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during rst
`define DR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dr_pkg.sv =====
// ----------------------------------------------------------------------------
// dr_pkg
// Shared constants, state encoding and divider request types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dr_pkg;

  localparam int MAX_STATES_DEF = 16;
  localparam int DUR_BITS_DEF   = 16;

  localparam int IN_W    = 16;  // input duration and target width
  localparam int TOT_W   = 20;  // reported total width
  localparam int STORE_W = 18;  // stored duration, wide enough for silence growth
  localparam int FRAC_W  = 16;  // fractional bits of the ratio
  localparam int Q_W     = 32;  // ratio width
  localparam int NUM_W   = 32;  // dividend width (target << 16)
  localparam int DEN_W   = 20;  // divisor width (group sum)

  localparam logic [TOT_W-1:0] TOT_MAX = '1;

  typedef enum logic [3:0] {
    S_LOAD,
    S_DISPATCH,
    S_SIL_RD,
    S_SIL_WR,
    S_GEN_CHK,
    S_DIV,
    S_SCALE,
    S_FIX_CHK,
    S_FIX_SCAN,
    S_FIX_WR,
    S_EMIT
  } dr_state_t;

  typedef struct packed {
    logic             go;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } dr_div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quo;
  } dr_div_rsp_t;

endpackage

// ===== design/duration_rescale.sv =====
// ----------------------------------------------------------------------------
// duration_rescale
// Rescales a group of per-state durations to a requested total frame count.
// ----------------------------------------------------------------------------
// Usage: drive start with one state's duration_in; it is taken when busy is
// low. Non-final states load and busy stays low, so a
// group streams in back to back. The state with is_last_in set also carries
// target_frames and silence_mode and closes the group; busy then rises.
// Items beyond MAX_STATES are dropped, a dropped final item still closes.
// The group is then rescaled out of the duration store while busy is high:
// a divide, a scaling pass, then fix-up rounds (check, scan, write-back),
// at most 2n+3 of them. All store reads go through the single read port.
// Results come out one per cycle on strobe, in state order, with
// is_last_out on the final one and total_frames on every one. The receiver
// cannot hold results off. busy falls the cycle after the last result.
// Reset clears the state count and running total; the store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "duration_rescale_assert.svh"

module duration_rescale #(
  parameter int MAX_STATES = dr_pkg::MAX_STATES_DEF,
  parameter int DUR_BITS   = dr_pkg::DUR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] duration_in,
  input  logic        is_last_in,
  input  logic [15:0] target_frames,
  input  logic        silence_mode,
  output logic        strobe,
  output logic [15:0] duration_out,
  output logic        is_last_out,
  output logic [19:0] total_frames
);

  localparam int IN_W    = dr_pkg::IN_W;
  localparam int TOT_W   = dr_pkg::TOT_W;
  localparam int STORE_W = dr_pkg::STORE_W;
  localparam int FRAC_W  = dr_pkg::FRAC_W;
  localparam int Q_W     = dr_pkg::Q_W;
  localparam int DEN_W   = dr_pkg::DEN_W;
  localparam int CNT_W   = $clog2(MAX_STATES + 1);
  localparam int IDX_W   = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int S_W     = TOT_W + CNT_W;
  localparam int IT_W    = CNT_W + 2;
  localparam int Y_W     = STORE_W + Q_W;
  localparam int V_W     = Y_W + 2;
  localparam int C_W     = FRAC_W + 2 + CNT_W;
  localparam int SAT_B   = (DUR_BITS < STORE_W) ? DUR_BITS : STORE_W;
  localparam logic [STORE_W-1:0] DMAX = STORE_W'((64'd1 << SAT_B) - 64'd1);
  localparam logic signed [V_W-1:0] V_HALF = V_W'(1 << (FRAC_W - 1));
  localparam logic signed [V_W-1:0] V_ONE  = V_W'(1 << FRAC_W);

  dr_pkg::dr_state_t state, state_next;

  logic [CNT_W-1:0]   count;
  logic [TOT_W-1:0]   run_tot;
  logic [CNT_W-1:0]   n_r;
  logic [S_W-1:0]     sum_r;
  logic [IN_W-1:0]    tgt_in;
  logic [IN_W-1:0]    tgt_r;
  logic               sil_r;
  logic [Q_W-1:0]     ratio_r;
  logic signed [C_W-1:0] carry_r;
  logic [IT_W-1:0]    it_r;
  logic [CNT_W-1:0]   ridx;
  logic               v1, v2;
  logic [IDX_W-1:0]   i1, i2;
  logic [Y_W-1:0]     y_r;
  logic [STORE_W-1:0] bv;
  logic [IDX_W-1:0]   bk;

  logic               acc;
  logic               has_room;
  logic [CNT_W-1:0]   cnt_after;
  logic [TOT_W:0]     tot_sum;
  logic [TOT_W-1:0]   tot_after;

  logic               mem_we, mem_re, scan_rd;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [STORE_W-1:0] mem_wdata, rdata;

  dr_pkg::dr_div_req_t div_req;
  dr_pkg::dr_div_rsp_t div_rsp;

  logic [IDX_W-1:0]   mid;
  logic               below;
  logic [IN_W-1:0]    tgt_val;
  logic               sil_rej;
  logic               sil_lt;
  logic [S_W-1:0]     diff, sil_sub_nd, sil_nd_w, sil_sum;
  logic [STORE_W-1:0] sil_nd;
  logic [Y_W-1:0]     y_mul;
  logic signed [V_W-1:0] v_val;
  logic               v_gt;
  logic [STORE_W-1:0] d_val;
  logic signed [C_W-1:0] carry_next;
  logic [S_W:0]       tdk, s_ext, fix_nd_w;
  logic               fix_go;
  logic [S_W-1:0]     fix_sum;
  logic [STORE_W-1:0] fix_nd;
  logic               emit_last;
  logic [STORE_W-1:0] d_sat;
  logic [TOT_W-1:0]   tot_sat;

  assign busy = (state != dr_pkg::S_LOAD);
  assign acc  = start && !busy;

  // load path: next count and saturating running total
  always_comb begin
    has_room  = count < CNT_W'(MAX_STATES);
    cnt_after = has_room ? count + CNT_W'(1) : count;
    tot_sum   = {1'b0, run_tot} + (TOT_W + 1)'(duration_in);
    if (!has_room) begin
      tot_after = run_tot;
    end else if (tot_sum > {1'b0, dr_pkg::TOT_MAX}) begin
      tot_after = dr_pkg::TOT_MAX;
    end else begin
      tot_after = tot_sum[TOT_W-1:0];
    end
  end

  // silence and general mode decisions
  always_comb begin
    mid        = IDX_W'(n_r >> 1);
    below      = sum_r < S_W'(n_r);
    tgt_val    = (tgt_in < IN_W'(n_r)) ? IN_W'(n_r) : tgt_in;
    sil_rej    = (sum_r == '0) || !n_r[0];
    sil_lt     = sum_r < S_W'(tgt_in);
    diff       = sum_r - S_W'(tgt_in);
    sil_sub_nd = (S_W'(rdata) < diff + S_W'(1)) ? S_W'(1) : S_W'(rdata) - diff;
    sil_nd_w   = sil_lt ? S_W'(rdata) + S_W'(tgt_in) - sum_r : sil_sub_nd;
    sil_nd     = STORE_W'(sil_nd_w);
    sil_sum    = sil_lt ? S_W'(tgt_in) : sum_r - S_W'(rdata) + sil_sub_nd;
  end

  // scaling: product, then rounding with carried error
  assign y_mul = Y_W'(rdata) * Y_W'(ratio_r);
  always_comb begin
    v_val = $signed({2'b00, y_r}) + V_W'(carry_r) + V_HALF;
    v_gt  = v_val > V_ONE;
    d_val = v_gt ? v_val[FRAC_W +: STORE_W] : STORE_W'(1);
    carry_next = v_gt ? C_W'($signed({1'b0, v_val[FRAC_W-1:0]}) - V_HALF)
                      : C_W'(v_val - V_HALF - V_ONE);
  end

  // fix-up: move the residue onto the first largest state
  always_comb begin
    tdk      = (S_W + 1)'(tgt_r) + (S_W + 1)'(bv);
    s_ext    = {1'b0, sum_r};
    fix_nd_w = (s_ext + (S_W + 1)'(1) < tdk) ? tdk - s_ext : (S_W + 1)'(1);
    fix_nd   = STORE_W'(fix_nd_w);
    fix_sum  = sum_r - S_W'(bv) + S_W'(fix_nd_w);
    fix_go   = (sum_r != S_W'(tgt_r)) &&
               (it_r <= IT_W'({n_r, 1'b0}) + IT_W'(2));
  end

  // output formatting
  always_comb begin
    emit_last = (CNT_W'(i1) + CNT_W'(1)) == n_r;
    d_sat     = (rdata > DMAX) ? DMAX : rdata;
    tot_sat   = (sum_r > S_W'(dr_pkg::TOT_MAX)) ? dr_pkg::TOT_MAX : sum_r[TOT_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dr_pkg::S_LOAD: begin
        if (acc && is_last_in) state_next = dr_pkg::S_DISPATCH;
      end
      dr_pkg::S_DISPATCH: begin
        if (!sil_r) begin
          state_next = dr_pkg::S_GEN_CHK;
        end else if (sil_rej || sum_r == S_W'(tgt_in)) begin
          state_next = dr_pkg::S_EMIT;
        end else begin
          state_next = dr_pkg::S_SIL_RD;
        end
      end
      dr_pkg::S_SIL_RD: state_next = dr_pkg::S_SIL_WR;
      dr_pkg::S_SIL_WR: begin
        if (sil_lt || sil_sum == S_W'(tgt_in)) state_next = dr_pkg::S_EMIT;
        else state_next = dr_pkg::S_GEN_CHK;
      end
      dr_pkg::S_GEN_CHK: begin
        state_next = below ? dr_pkg::S_EMIT : dr_pkg::S_DIV;
      end
      dr_pkg::S_DIV: begin
        if (div_rsp.done) state_next = dr_pkg::S_SCALE;
      end
      dr_pkg::S_SCALE: begin
        if (ridx == n_r && !v1 && !v2) state_next = dr_pkg::S_FIX_CHK;
      end
      dr_pkg::S_FIX_CHK: begin
        state_next = fix_go ? dr_pkg::S_FIX_SCAN : dr_pkg::S_EMIT;
      end
      dr_pkg::S_FIX_SCAN: begin
        if (ridx == n_r && !v1) state_next = dr_pkg::S_FIX_WR;
      end
      dr_pkg::S_FIX_WR: state_next = dr_pkg::S_FIX_CHK;
      dr_pkg::S_EMIT: begin
        if (ridx == n_r && !v1) state_next = dr_pkg::S_LOAD;
      end
      default: state_next = dr_pkg::S_LOAD;
    endcase
  end

  // store port and divider request per state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[IDX_W-1:0];
    mem_wdata = STORE_W'(duration_in);
    mem_re    = 1'b0;
    mem_raddr = ridx[IDX_W-1:0];
    scan_rd   = 1'b0;
    div_req.go  = 1'b0;
    div_req.num = {tgt_val, 16'b0};
    div_req.den = sum_r[DEN_W-1:0];
    unique case (state)
      dr_pkg::S_LOAD: begin
        mem_we = acc && has_room;
      end
      dr_pkg::S_SIL_RD: begin
        mem_re    = 1'b1;
        mem_raddr = mid;
      end
      dr_pkg::S_SIL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = mid;
        mem_wdata = sil_nd;
      end
      dr_pkg::S_GEN_CHK: begin
        div_req.go = !below;
      end
      dr_pkg::S_SCALE: begin
        scan_rd   = ridx < n_r;
        mem_re    = scan_rd;
        mem_we    = v2;
        mem_waddr = i2;
        mem_wdata = d_val;
      end
      dr_pkg::S_FIX_SCAN, dr_pkg::S_EMIT: begin
        scan_rd = ridx < n_r;
        mem_re  = scan_rd;
      end
      dr_pkg::S_FIX_WR: begin
        mem_we    = 1'b1;
        mem_waddr = bk;
        mem_wdata = fix_nd;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dr_pkg::S_LOAD;
      count       <= '0;
      run_tot     <= '0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      strobe      <= 1'b0;
      is_last_out <= 1'b0;
    end else begin
      state       <= state_next;
      v1          <= scan_rd;
      v2          <= (state == dr_pkg::S_SCALE) && v1;
      strobe      <= (state == dr_pkg::S_EMIT) && v1;
      is_last_out <= (state == dr_pkg::S_EMIT) && v1 && emit_last;
      if (acc) begin
        count   <= is_last_in ? '0 : cnt_after;
        run_tot <= is_last_in ? '0 : tot_after;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    i1 <= ridx[IDX_W-1:0];
    i2 <= i1;
    if (state_next != state) begin
      ridx <= '0;
    end else if (scan_rd) begin
      ridx <= ridx + CNT_W'(1);
    end
    if (state == dr_pkg::S_EMIT && v1) begin
      duration_out <= d_sat[15:0];
      total_frames <= tot_sat;
    end
    unique case (state)
      dr_pkg::S_LOAD: begin
        if (acc && is_last_in) begin
          n_r    <= cnt_after;
          sum_r  <= S_W'(tot_after);
          tgt_in <= target_frames;
          sil_r  <= silence_mode;
        end
      end
      dr_pkg::S_DISPATCH: begin
        if (sil_r && sil_rej) sum_r <= '0;
      end
      dr_pkg::S_SIL_WR: sum_r <= sil_sum;
      dr_pkg::S_GEN_CHK: tgt_r <= tgt_val;
      dr_pkg::S_DIV: begin
        if (div_rsp.done) begin
          ratio_r <= div_rsp.quo;
          carry_r <= '0;
          sum_r   <= '0;
          it_r    <= '0;
        end
      end
      dr_pkg::S_SCALE: begin
        if (v1) y_r <= y_mul;
        if (v2) begin
          carry_r <= carry_next;
          sum_r   <= sum_r + S_W'(d_val);
        end
      end
      dr_pkg::S_FIX_SCAN: begin
        if (v1 && (i1 == '0 || rdata > bv)) begin
          bv <= rdata;
          bk <= i1;
        end
      end
      dr_pkg::S_FIX_WR: begin
        sum_r <= fix_sum;
        it_r  <= it_r + IT_W'(1);
      end
      default: ;
    endcase
  end

  dr_mem #(
    .DEPTH(MAX_STATES)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  dr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // checks
  `DR_ASSERT_IMP(a_res_from_busy, strobe, $past(busy), "result without busy group")
  `DR_ASSERT_NXT(a_load_no_stall, acc && !is_last_in, !busy, "load stalled the port")
  `DR_ASSERT_IMP(a_last_on_strobe, is_last_out, strobe, "last flag without result")
  `DR_ASSERT_IMP(a_div_in_wait, div_rsp.done, state == dr_pkg::S_DIV, "stray divider result")

endmodule

// ===== design/dr_mem.sv =====
// ----------------------------------------------------------------------------
// dr_mem
// Duration store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dr_mem #(
  parameter int DEPTH = dr_pkg::MAX_STATES_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [dr_pkg::STORE_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [dr_pkg::STORE_W-1:0] rdata
);

  logic [dr_pkg::STORE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered, updated only when re is high
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/dr_div.sv =====
// ----------------------------------------------------------------------------
// dr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dr_div (
  input  logic                clk,
  input  logic                rst,
  input  dr_pkg::dr_div_req_t req,
  output dr_pkg::dr_div_rsp_t rsp
);

  localparam int NUM_W = dr_pkg::NUM_W;
  localparam int DEN_W = dr_pkg::DEN_W;
  localparam int CW    = $clog2(NUM_W);

  logic             run;
  logic             done;
  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   rem_sh;
  logic             q_bit;
  logic [DEN_W-1:0] rem_next;

  // trial subtract
  always_comb begin
    rem_sh   = {rem, quo[NUM_W-1]};
    q_bit    = rem_sh >= {1'b0, den};
    rem_next = q_bit ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        run <= 1'b1;
      end else if (run && cnt == CW'(NUM_W - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    if (req.go) begin
      cnt <= '0;
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (run) begin
      cnt <= cnt + CW'(1);
      rem <= rem_next;
      quo <= {quo[NUM_W-2:0], q_bit};
    end
  end

  assign rsp = '{done: done, quo: quo};

endmodule
